@@ rtl/core/pesev_pkg.sv @@
// Shared constants and types for the prefix expression stack evaluator.
package pesev_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned CHAR_W          = 8;
  localparam int unsigned CFG_W           = 4;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned DEF_STACK_DEPTH = 8;

  localparam logic [CFG_W-1:0] LIMIT_RESET = 4'd5;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/core/prefix_expression_stack_evaluator_top.sv @@
// Prefix expression evaluator: sequencer around a synchronous stack memory.
//
// Bytes of a prefix expression enter on the s_axis channel, rightmost byte
// first; s_axis_tlast marks the leftmost byte. Operands push (byte - 48),
// and + - * / pop two entries and push the 32-bit result. After the byte
// with tlast, one transaction leaves on m_axis carrying the top of stack
// (0 when empty) and the first error seen, then the stack and error clear.
// The cfg channel writes stack_limit and is always ready; stack_limit must be
// written only while the block is idle, which the block itself does not enforce.
// One byte is taken at a time. An operand goes to S_PUSH; + - * go via S_POP1,
// S_POP2, S_CALC, S_EXEC, S_PUSH; / also waits in S_DIV on the one-bit-per-cycle
// divider unless the divisor is 0. A last byte adds S_TOP, the top-of-stack read.
// Every stack access goes through the single-port stack memory, one read or
// write per cycle, so the pops and the push are sequenced.
// Reset empties the stack, clears the error and sets stack_limit to 5; the
// memory contents are not cleared. While the result waits on a stalled
// m_axis, further bytes are still accepted; only the next result waits.
module prefix_expression_stack_evaluator_top #(
  parameter int unsigned STACK_DEPTH = pesev_pkg::DEF_STACK_DEPTH
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [pesev_pkg::CFG_W-1:0]             cfg_data_i,     // stack_limit
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [pesev_pkg::CHAR_W-1:0]            s_axis_tdata,   // char_code
  input  logic                                    s_axis_tlast,   // last_char
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  output logic signed [pesev_pkg::DATA_W-1:0]     m_axis_tdata,   // value
  output logic [pesev_pkg::STATUS_W-1:0]          m_axis_tuser    // status
);
  import pesev_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_POP1, S_POP2, S_CALC, S_EXEC, S_DIV, S_PUSH, S_TOP, S_OUT
  } state_e;

  state_e              state_q;
  logic [CW-1:0]       count_q;
  logic [STATUS_W-1:0] err_q;
  logic [CFG_W-1:0]    limit_q;
  logic [CHAR_W-1:0]   char_q;
  logic                last_q;
  logic                hit_q;
  logic                neg_q;
  logic [DATA_W-1:0]   op1_q;
  logic [DATA_W-1:0]   op2_q;
  logic [DATA_W-1:0]   res_q;
  logic                out_valid_q;
  logic [DATA_W-1:0]   out_value_q;
  logic [STATUS_W-1:0] out_status_q;

  logic [DATA_W-1:0]   mem [STACK_DEPTH];
  logic [DATA_W-1:0]   rdata_q;

  logic                mem_re;
  logic                mem_we;
  logic [CW-1:0]       count_m1;
  logic                stack_full;
  logic                in_is_op;
  logic                out_free;
  logic [DATA_W-1:0]   mag1;
  logic [DATA_W-1:0]   mag2;
  logic [DATA_W-1:0]   product;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_status_q;

  assign in_is_op = (s_axis_tdata == CHAR_PLUS) || (s_axis_tdata == CHAR_MINUS) ||
                    (s_axis_tdata == CHAR_STAR) || (s_axis_tdata == CHAR_SLASH);

  assign count_m1   = count_q - 1'b1;
  assign stack_full = (32'(count_q) >= 32'(limit_q)) || (32'(count_q) >= 32'(STACK_DEPTH));
  assign out_free   = !out_valid_q || m_axis_tready;

  assign mem_re = ((state_q == S_POP1) || (state_q == S_POP2) || (state_q == S_TOP)) &&
                  (count_q != '0);
  assign mem_we = (state_q == S_PUSH) && !stack_full;

  assign mag1    = op1_q[DATA_W-1] ? (DATA_W'(0) - op1_q) : op1_q;
  assign mag2    = op2_q[DATA_W-1] ? (DATA_W'(0) - op2_q) : op2_q;
  assign product = op1_q * op2_q;

  assign div_req.start    = (state_q == S_EXEC) && (char_q == CHAR_SLASH) && (op2_q != '0);
  assign div_req.dividend = mag1;
  assign div_req.divisor  = mag2;

  pesev_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Stack memory: one access per cycle, read data registered.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[AW-1:0]] <= res_q;
    end
    if (mem_re) begin
      rdata_q <= mem[count_m1[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      err_q        <= ST_OK;
      limit_q      <= LIMIT_RESET;
      out_valid_q  <= 1'b0;
      char_q       <= '0;
      last_q       <= 1'b0;
      hit_q        <= 1'b0;
      neg_q        <= 1'b0;
      op1_q        <= '0;
      op2_q        <= '0;
      res_q        <= '0;
      out_value_q  <= '0;
      out_status_q <= ST_OK;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            char_q <= s_axis_tdata;
            last_q <= s_axis_tlast;
            res_q  <= DATA_W'(s_axis_tdata) - DATA_W'(CHAR_ZERO);
            state_q <= in_is_op ? S_POP1 : S_PUSH;
          end
        end
        S_POP1: begin
          hit_q <= (count_q != '0);
          if (count_q == '0) begin
            if (err_q == ST_OK) err_q <= ST_UNDER;
          end else begin
            count_q <= count_m1;
          end
          state_q <= S_POP2;
        end
        S_POP2: begin
          op1_q <= hit_q ? rdata_q : '0;
          hit_q <= (count_q != '0);
          if (count_q == '0) begin
            if (err_q == ST_OK) err_q <= ST_UNDER;
          end else begin
            count_q <= count_m1;
          end
          state_q <= S_CALC;
        end
        S_CALC: begin
          op2_q   <= hit_q ? rdata_q : '0;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          neg_q <= op1_q[DATA_W-1] ^ op2_q[DATA_W-1];
          case (char_q)
            CHAR_PLUS: begin
              res_q   <= op1_q + op2_q;
              state_q <= S_PUSH;
            end
            CHAR_MINUS: begin
              res_q   <= op1_q - op2_q;
              state_q <= S_PUSH;
            end
            CHAR_STAR: begin
              res_q   <= product;
              state_q <= S_PUSH;
            end
            default: begin
              if (op2_q == '0) begin
                if (err_q == ST_OK) err_q <= ST_DIVZ;
                res_q   <= '0;
                state_q <= S_PUSH;
              end else begin
                state_q <= S_DIV;
              end
            end
          endcase
        end
        S_DIV: begin
          if (div_rsp.done) begin
            res_q   <= neg_q ? (DATA_W'(0) - div_rsp.quotient) : div_rsp.quotient;
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (stack_full) begin
            if (err_q == ST_OK) err_q <= ST_OVER;
          end else begin
            count_q <= count_q + 1'b1;
          end
          state_q <= last_q ? S_TOP : S_IDLE;
        end
        S_TOP: begin
          hit_q   <= (count_q != '0);
          state_q <= S_OUT;
        end
        S_OUT: begin
          // The previous result must be gone before this one is loaded.
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_value_q  <= hit_q ? rdata_q : '0;
            out_status_q <= err_q;
            count_q      <= '0;
            err_q        <= ST_OK;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/pesev_div.sv @@
// Unsigned restoring divider that retires one quotient bit per cycle.
module pesev_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pesev_pkg::div_req_t req_i,
  output pesev_pkg::div_rsp_t rsp_o
);
  import pesev_pkg::*;

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DATA_W-1:0] rem_q;
  logic [DATA_W-1:0] quo_q;
  logic [DATA_W-1:0] dvs_q;
  logic [DATA_W:0]   rem_shift;
  logic [DATA_W:0]   diff;

  assign rem_shift = {rem_q, quo_q[DATA_W-1]};
  assign diff      = rem_shift - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DATA_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out of the quotient register as quotient bits shift in.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      if (!diff[DATA_W]) begin
        rem_q <= diff[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_shift[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
